>>> sv/bscp_pkg.sv
// Package: shared types, constants and character helpers for the servo command parser.
`timescale 1ns / 1ps
package bscp_pkg;

  localparam int CMD_CAPACITY_DEF = 64;
  localparam int MAG_W = 10;
  localparam logic [MAG_W-1:0] MAG_MAX = 10'd1023;
  localparam int NUM_KEYS = 4;

  localparam logic [7:0] CH_OPEN  = 8'h3C;
  localparam logic [7:0] CH_CLOSE = 8'h3E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [7:0] KEY_LETTER [NUM_KEYS] = '{8'h50, 8'h54, 8'h4C, 8'h46};

  localparam logic [1:0] KEY_PAN   = 2'd0;
  localparam logic [1:0] KEY_TILT  = 2'd1;
  localparam logic [1:0] KEY_LASER = 2'd2;
  localparam logic [1:0] KEY_FRAME = 2'd3;

  localparam logic [1:0] REG_PAN_LOW   = 2'd0;
  localparam logic [1:0] REG_PAN_HIGH  = 2'd1;
  localparam logic [1:0] REG_TILT_LOW  = 2'd2;
  localparam logic [1:0] REG_TILT_HIGH = 2'd3;

  localparam logic [7:0] LIMIT_LOW_RST  = 8'd0;
  localparam logic [7:0] LIMIT_HIGH_RST = 8'd180;
  localparam logic [7:0] HELD_ANGLE_RST = 8'd90;

  typedef enum logic [1:0] {
    PH_NONE = 2'd0,
    PH_WS   = 2'd1,
    PH_NUM  = 2'd2,
    PH_DONE = 2'd3
  } key_phase_t;

  typedef struct packed {
    key_phase_t       phase;
    logic             negative;
    logic [MAG_W-1:0] magnitude;
  } key_state_t;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

>>> sv/bscp_key_parser.sv
// Key parser: finds the first "X:" key and reads the signed, saturated integer after it.
`timescale 1ns / 1ps
module bscp_key_parser #(
  parameter logic [7:0] KEY = 8'h50
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                step,
  input  logic [7:0]          rx_char,
  input  logic [7:0]          prev_char,
  output bscp_pkg::key_state_t key_state
);
  import bscp_pkg::*;

  key_phase_t       phase;
  key_phase_t       phase_next;
  logic             negative;
  logic             negative_next;
  logic [MAG_W-1:0] magnitude;
  logic [MAG_W-1:0] magnitude_next;
  logic [MAG_W+3:0] product;

  assign product = (MAG_W+4)'({magnitude, 3'b000}) + (MAG_W+4)'({magnitude, 1'b0})
                 + (MAG_W+4)'(rx_char[3:0]);

  always_comb begin
    phase_next = phase;
    if (clear) begin
      phase_next = PH_NONE;
    end else if (step) begin
      unique case (phase)
        PH_NONE: begin
          if (prev_char == KEY && rx_char == CH_COLON) phase_next = PH_WS;
        end
        PH_WS: begin
          if (is_ws(rx_char)) phase_next = PH_WS;
          else if (rx_char == CH_PLUS || rx_char == CH_MINUS || is_digit(rx_char))
            phase_next = PH_NUM;
          else phase_next = PH_DONE;
        end
        PH_NUM: begin
          if (!is_digit(rx_char)) phase_next = PH_DONE;
        end
        PH_DONE: phase_next = PH_DONE;
      endcase
    end
  end

  always_comb begin
    negative_next  = negative;
    magnitude_next = magnitude;
    if (clear) begin
      negative_next  = 1'b0;
      magnitude_next = '0;
    end else if (step) begin
      case (phase)
        PH_NONE: begin
          if (prev_char == KEY && rx_char == CH_COLON) begin
            negative_next  = 1'b0;
            magnitude_next = '0;
          end
        end
        PH_WS: begin
          if (!is_ws(rx_char)) begin
            if (rx_char == CH_PLUS || rx_char == CH_MINUS) begin
              negative_next = (rx_char == CH_MINUS);
            end else if (is_digit(rx_char)) begin
              magnitude_next = MAG_W'(rx_char[3:0]);
            end
          end
        end
        PH_NUM: begin
          if (is_digit(rx_char)) begin
            magnitude_next = (product > (MAG_W+4)'(MAG_MAX)) ? MAG_MAX : product[MAG_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_NONE;
      negative  <= 1'b0;
      magnitude <= '0;
    end else begin
      phase     <= phase_next;
      negative  <= negative_next;
      magnitude <= magnitude_next;
    end
  end

  assign key_state = '{phase: phase, negative: negative, magnitude: magnitude};

endmodule

>>> sv/bracketed_servo_command_parser_top.sv
// Top level: bracketed servo command parser with APB limit registers.
// A closing '>' word is held in the input register s1_byte, then loads the output register.
// Throughput: one byte per cycle; a '>' stalls only while the previous result waits.
// Other bytes keep flowing while a result is pending in the output register.
// Reset (synchronous, rst high): limits 0/180/0/180, held pan and tilt 90, laser off,
// no command open, all key parsers cleared.
`timescale 1ns / 1ps
module bracketed_servo_command_parser_top #(
  parameter int CMD_CAPACITY = bscp_pkg::CMD_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  pan_angle,
  output logic [7:0]  tilt_angle,
  output logic        laser_enable,
  output logic        frame_request,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bscp_pkg::*;

  localparam int CNT_W = $clog2(CMD_CAPACITY);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CMD_CAPACITY - 1);

  logic [7:0] pan_low, pan_high, tilt_low, tilt_high;
  logic [1:0] reg_index;
  logic       reg_write;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       in_command;
  logic [CNT_W-1:0] stored_count;
  logic [7:0] previous_char;
  logic       string_ended;
  logic [7:0] held_pan, held_tilt;
  logic       held_laser;

  logic       is_open, is_close, produce, advance, room, take, feed, clear_cmd;
  logic [7:0] pan_next, tilt_next;
  logic       laser_next, frame_next;
  key_state_t keys [NUM_KEYS];

  function automatic logic [7:0] clamp(input logic neg, input logic [MAG_W-1:0] mag,
                                       input logic [7:0] lo, input logic [7:0] hi);
    logic [MAG_W-1:0] v;
    v = neg ? '0 : mag;
    if (neg && mag != '0) clamp = lo;
    else if (v < MAG_W'(lo)) clamp = lo;
    else if (v > MAG_W'(hi)) clamp = hi;
    else clamp = v[7:0];
  endfunction

  // Configuration port
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign reg_write = psel && penable && pwrite;

  always_comb begin
    unique case (reg_index)
      REG_PAN_LOW:   prdata = {24'd0, pan_low};
      REG_PAN_HIGH:  prdata = {24'd0, pan_high};
      REG_TILT_LOW:  prdata = {24'd0, tilt_low};
      REG_TILT_HIGH: prdata = {24'd0, tilt_high};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pan_low   <= LIMIT_LOW_RST;
      pan_high  <= LIMIT_HIGH_RST;
      tilt_low  <= LIMIT_LOW_RST;
      tilt_high <= LIMIT_HIGH_RST;
    end else if (reg_write) begin
      unique case (reg_index)
        REG_PAN_LOW:   pan_low   <= pwdata[7:0];
        REG_PAN_HIGH:  pan_high  <= pwdata[7:0];
        REG_TILT_LOW:  tilt_low  <= pwdata[7:0];
        REG_TILT_HIGH: tilt_high <= pwdata[7:0];
      endcase
    end
  end

  // Byte decode and stage control
  assign is_open   = (s1_byte == CH_OPEN);
  assign is_close  = (s1_byte == CH_CLOSE);
  assign produce   = s1_valid && is_close && in_command;
  assign advance   = s1_valid && (!produce || !out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;
  assign clear_cmd = advance && (is_open || (is_close && in_command));
  assign room      = stored_count < CNT_LAST;
  assign take      = advance && in_command && !is_open && !is_close && room;
  assign feed      = take && !string_ended && (s1_byte != CH_NUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_byte <= rx_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_command    <= 1'b0;
      stored_count  <= '0;
      previous_char <= CH_NUL;
      string_ended  <= 1'b0;
    end else if (clear_cmd) begin
      in_command    <= is_open;
      stored_count  <= '0;
      previous_char <= CH_NUL;
      string_ended  <= 1'b0;
    end else if (take) begin
      stored_count <= stored_count + 1'b1;
      if (!string_ended && s1_byte == CH_NUL) string_ended <= 1'b1;
      if (feed) previous_char <= s1_byte;
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    bscp_key_parser #(
      .KEY(KEY_LETTER[k])
    ) u_key (
      .clk       (clk),
      .rst       (rst),
      .clear     (clear_cmd),
      .step      (feed),
      .rx_char   (s1_byte),
      .prev_char (previous_char),
      .key_state (keys[k])
    );
  end

  // Command close
  always_comb begin
    pan_next = (keys[KEY_PAN].phase != PH_NONE)
        ? clamp(keys[KEY_PAN].negative, keys[KEY_PAN].magnitude, pan_low, pan_high)
        : clamp(1'b0, MAG_W'(held_pan), pan_low, pan_high);
    tilt_next = (keys[KEY_TILT].phase != PH_NONE)
        ? clamp(keys[KEY_TILT].negative, keys[KEY_TILT].magnitude, tilt_low, tilt_high)
        : clamp(1'b0, MAG_W'(held_tilt), tilt_low, tilt_high);
    laser_next = (keys[KEY_LASER].phase != PH_NONE)
        ? (keys[KEY_LASER].magnitude != '0) : held_laser;
    frame_next = (keys[KEY_FRAME].phase != PH_NONE) && !keys[KEY_FRAME].negative
        && (keys[KEY_FRAME].magnitude == MAG_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_pan   <= HELD_ANGLE_RST;
      held_tilt  <= HELD_ANGLE_RST;
      held_laser <= 1'b0;
    end else if (advance && produce) begin
      held_pan   <= pan_next;
      held_tilt  <= tilt_next;
      held_laser <= laser_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      pan_angle     <= pan_next;
      tilt_angle    <= tilt_next;
      laser_enable  <= laser_next;
      frame_request <= frame_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_keys_clear: assert property (@(posedge clk) disable iff (rst)
    !in_command |-> (keys[KEY_PAN].phase == PH_NONE && keys[KEY_TILT].phase == PH_NONE
                     && keys[KEY_LASER].phase == PH_NONE && keys[KEY_FRAME].phase == PH_NONE))
    else $error("key parser active outside a command");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CNT_LAST)
    else $error("stored count beyond capacity");
  a_ended_in_cmd: assert property (@(posedge clk) disable iff (rst)
    string_ended |-> in_command)
    else $error("string end flag set outside a command");
  a_close_result: assert property (@(posedge clk) disable iff (rst)
    (advance && produce) |=> (out_valid && !in_command))
    else $error("closing word did not load a result");
  a_close_stall: assert property (@(posedge clk) disable iff (rst)
    (produce && out_valid && !out_ready) |=> (s1_valid && $stable(s1_byte) && in_command))
    else $error("closing word lost while output stalled");
`endif

endmodule

>>> dv/tb_bracketed_servo_command_parser_top.sv
// Testbench for the servo command parser: random and directed command words, limit writes.
`timescale 1ns / 1ps
module tb_bracketed_servo_command_parser_top;
  import bscp_pkg::*;

  localparam int IDLE_PCT = 18;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BYTES = 190;
  localparam int NUM_PHASES = 5;
  localparam logic [7:0] CH_DIGIT0 = 8'h30;
  localparam logic [7:0] CH_DIGIT9 = 8'h39;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  typedef struct packed {
    logic [7:0] pan;
    logic [7:0] tilt;
    logic       laser;
    logic       frame;
  } servo_setting_t;

  class servo_cmd_scoreboard;
    logic [7:0] limit [4];
    bit open;
    int unsigned kept;
    logic [7:0] last_ch;
    bit cut;
    key_state_t keys [NUM_KEYS];
    logic [7:0] pan_hold;
    logic [7:0] tilt_hold;
    logic laser_hold;
    servo_setting_t pending_settings [$];
    int mismatches;

    function new();
      limit[REG_PAN_LOW] = LIMIT_LOW_RST;
      limit[REG_PAN_HIGH] = LIMIT_HIGH_RST;
      limit[REG_TILT_LOW] = LIMIT_LOW_RST;
      limit[REG_TILT_HIGH] = LIMIT_HIGH_RST;
      open = 1'b0;
      pan_hold = HELD_ANGLE_RST;
      tilt_hold = HELD_ANGLE_RST;
      laser_hold = 1'b0;
      mismatches = 0;
      clear_keys();
    endfunction

    function void write_limit(logic [1:0] idx, logic [7:0] val);
      limit[idx] = val;
    endfunction

    function void clear_keys();
      kept = 0;
      last_ch = CH_NUL;
      cut = 1'b0;
      foreach (keys[k]) begin
        keys[k].phase = PH_NONE;
        keys[k].negative = 1'b0;
        keys[k].magnitude = '0;
      end
    endfunction

    function bit blank(logic [7:0] c);
      return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function bit digit(logic [7:0] c);
      return c >= CH_DIGIT0 && c <= CH_DIGIT9;
    endfunction

    function void advance_key(int k, logic [7:0] c);
      int m;
      case (keys[k].phase)
        PH_NONE: begin
          if (last_ch == KEY_LETTER[k] && c == CH_COLON) begin
            keys[k].phase = PH_WS;
            keys[k].negative = 1'b0;
            keys[k].magnitude = '0;
          end
        end
        PH_WS: begin
          if (!blank(c)) begin
            if (c == CH_PLUS || c == CH_MINUS) begin
              keys[k].negative = (c == CH_MINUS);
              keys[k].phase = PH_NUM;
            end else if (digit(c)) begin
              keys[k].magnitude = MAG_W'(c - CH_DIGIT0);
              keys[k].phase = PH_NUM;
            end else begin
              keys[k].phase = PH_DONE;
            end
          end
        end
        PH_NUM: begin
          if (digit(c)) begin
            m = int'(keys[k].magnitude) * 10 + int'(c - CH_DIGIT0);
            keys[k].magnitude = (m > int'(MAG_MAX)) ? MAG_MAX : m[MAG_W-1:0];
          end else begin
            keys[k].phase = PH_DONE;
          end
        end
        default: ;
      endcase
    endfunction

    function logic [7:0] clamp_angle(bit neg, int mag, logic [7:0] lo, logic [7:0] hi);
      if (neg && mag != 0) return lo;
      if (neg) mag = 0;
      if (mag < int'(lo)) return lo;
      if (mag > int'(hi)) return hi;
      return mag[7:0];
    endfunction

    function void note_byte(logic [7:0] c);
      servo_setting_t s;
      if (c == CH_OPEN) begin
        open = 1'b1;
        clear_keys();
      end else if (c == CH_CLOSE && open) begin
        if (keys[KEY_PAN].phase != PH_NONE)
          pan_hold = clamp_angle(keys[KEY_PAN].negative, keys[KEY_PAN].magnitude,
                                 limit[REG_PAN_LOW], limit[REG_PAN_HIGH]);
        else
          pan_hold = clamp_angle(1'b0, pan_hold, limit[REG_PAN_LOW], limit[REG_PAN_HIGH]);
        if (keys[KEY_TILT].phase != PH_NONE)
          tilt_hold = clamp_angle(keys[KEY_TILT].negative, keys[KEY_TILT].magnitude,
                                  limit[REG_TILT_LOW], limit[REG_TILT_HIGH]);
        else
          tilt_hold = clamp_angle(1'b0, tilt_hold, limit[REG_TILT_LOW], limit[REG_TILT_HIGH]);
        if (keys[KEY_LASER].phase != PH_NONE)
          laser_hold = keys[KEY_LASER].magnitude != '0;
        s.pan = pan_hold;
        s.tilt = tilt_hold;
        s.laser = laser_hold;
        s.frame = keys[KEY_FRAME].phase != PH_NONE && !keys[KEY_FRAME].negative
                  && keys[KEY_FRAME].magnitude == MAG_W'(1);
        pending_settings.push_back(s);
        open = 1'b0;
        clear_keys();
      end else if (open && kept < CMD_CAPACITY_DEF - 1) begin
        kept++;
        if (!cut) begin
          if (c == CH_NUL) begin
            cut = 1'b1;
          end else begin
            for (int k = 0; k < NUM_KEYS; k++) advance_key(k, c);
            last_ch = c;
          end
        end
      end
    endfunction

    task report_mismatch(string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_setting(servo_setting_t got);
      servo_setting_t want;
      if (pending_settings.size() == 0) begin
        report_mismatch($sformatf("unexpected word pan %0d tilt %0d laser %0b frame %0b",
                                  got.pan, got.tilt, got.laser, got.frame));
        return;
      end
      want = pending_settings.pop_front();
      if (got.pan != want.pan)
        report_mismatch($sformatf("pan_angle %0d, want %0d", got.pan, want.pan));
      if (got.tilt != want.tilt)
        report_mismatch($sformatf("tilt_angle %0d, want %0d", got.tilt, want.tilt));
      if (got.laser != want.laser)
        report_mismatch($sformatf("laser_enable %0b, want %0b", got.laser, want.laser));
      if (got.frame != want.frame)
        report_mismatch($sformatf("frame_request %0b, want %0b", got.frame, want.frame));
    endtask
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_ready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'h0;
  logic [31:0] pwdata = 32'h0;
  logic        in_ready;
  logic        out_valid;
  logic [7:0]  pan_angle;
  logic [7:0]  tilt_angle;
  logic        laser_enable;
  logic        frame_request;
  logic [31:0] prdata;
  logic        pready;

  bit steady = 1'b0;
  int unsigned quiet_cycles = 0;
  logic [7:0] burst [$];
  servo_cmd_scoreboard sb = new();

  bracketed_servo_command_parser_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pan_angle(pan_angle),
    .tilt_angle(tilt_angle),
    .laser_enable(laser_enable),
    .frame_request(frame_request),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && in_ready) sb.note_byte(rx_byte);
      if (out_valid && out_ready)
        sb.check_setting({pan_angle, tilt_angle, laser_enable, frame_request});
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL bracketed_servo_command_parser_top");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic flush_burst();
    foreach (burst[i]) send_byte(burst[i]);
    burst.delete();
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_settings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [1:0] idx, logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_limit(idx, val);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] != val)
      sb.report_mismatch($sformatf("limit %0d reads %0d, want %0d", idx, prdata[7:0], val));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void add_value(bit frame_key);
    int pick;
    int n;
    if (frame_key && $urandom_range(9) < 4) begin
      burst.push_back(CH_DIGIT0 + 8'd1);
      return;
    end
    pick = $urandom_range(9);
    if (pick == 0) burst.push_back(8'h09 + 8'($urandom_range(4)));
    else if (pick == 1) burst.push_back(CH_SPACE);
    pick = $urandom_range(9);
    if (pick < 2) burst.push_back(CH_MINUS);
    else if (pick == 2) burst.push_back(CH_PLUS);
    pick = $urandom_range(19);
    n = (pick == 0) ? 0 : (pick < 17) ? $urandom_range(1, 3) : $urandom_range(4, 6);
    repeat (n) burst.push_back(CH_DIGIT0 + 8'($urandom_range(9)));
  endfunction

  function automatic void add_command();
    int k;
    burst.push_back(CH_OPEN);
    repeat ($urandom_range(4)) begin
      k = $urandom_range(NUM_KEYS - 1);
      burst.push_back(KEY_LETTER[k]);
      burst.push_back(CH_COLON);
      add_value(k == KEY_FRAME);
      if ($urandom_range(9) < 6) burst.push_back(CH_COMMA);
      else burst.push_back(8'h20 + 8'($urandom_range(94)));
      if ($urandom_range(24) == 0) burst.push_back(CH_OPEN);
      if ($urandom_range(29) == 0) burst.push_back(CH_NUL);
    end
    burst.push_back(CH_CLOSE);
  endfunction

  function automatic void add_overflow();
    burst.push_back(CH_OPEN);
    repeat ($urandom_range(50, 66)) burst.push_back(8'h61 + 8'($urandom_range(25)));
    burst.push_back(KEY_LETTER[KEY_PAN]);
    burst.push_back(CH_COLON);
    add_value(1'b0);
    repeat ($urandom_range(8)) burst.push_back(8'h61 + 8'($urandom_range(25)));
    burst.push_back(CH_CLOSE);
  endfunction

  function automatic void add_noise();
    repeat ($urandom_range(1, 6)) burst.push_back(8'($urandom_range(255)));
  endfunction

  initial begin
    logic [7:0] limits [NUM_PHASES][4];
    int sent;
    int pick;
    limits = '{'{8'd0, 8'd180, 8'd0, 8'd180}, '{8'd0, 8'd255, 8'd0, 8'd255},
               '{8'd255, 8'd0, 8'd200, 8'd10}, '{8'd40, 8'd140, 8'd90, 8'd90},
               '{8'd0, 8'd0, 8'd255, 8'd255}};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_byte(8'hFF);
    send_byte(CH_CLOSE);
    send_text("<P:200T:-5L:-0F:1>");
    send_text("<P: 45<T:\t+30 >");
    send_text("<L:x F:01>");
    send_text("<P:7");
    send_byte(CH_NUL);
    send_text("T:9>");
    send_text("<P:99999L:3F:-1>");
    send_text("<>");

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      for (int i = 0; i < 4; i++) begin
        if (p == NUM_PHASES - 1 && $urandom_range(1) == 1)
          write_limit(2'(i), 8'($urandom_range(255)));
        else
          write_limit(2'(i), limits[p][i]);
      end
      @(posedge clk);
      steady = (p == 2);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        pick = $urandom_range(99);
        if (pick < 76) add_command();
        else if (pick < 80) add_overflow();
        else add_noise();
        sent += burst.size();
        flush_burst();
      end
    end

    wait_idle();
    if (sb.mismatches == 0) begin
      $display("PASS bracketed_servo_command_parser_top");
    end else begin
      $display("FAIL bracketed_servo_command_parser_top");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/bscp_pkg.sv
sv/bscp_key_parser.sv
sv/bracketed_servo_command_parser_top.sv
dv/tb_bracketed_servo_command_parser_top.sv
